>>> hw/rtl/bsmht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsmht_pkg;

    localparam logic [1:0] ACT_MSG   = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [1:0] ST_RECORDED = 2'd0;
    localparam logic [1:0] ST_DROPPED  = 2'd1;
    localparam logic [1:0] ST_TRUNC    = 2'd2;
    localparam logic [1:0] ST_READ     = 2'd3;

    localparam logic [31:0] TOTAL_LIMIT    = 32'hFFFF_FFF0;
    localparam logic [7:0]  BROADCAST_ADDR = 8'h00;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  msg_byte;
        logic        msg_last;
        logic [31:0] time_stamp;
        logic [7:0]  read_rank;
        logic [1:0]  read_slot;
        logic [7:0]  read_position;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  entry_rank;
        logic [7:0]  slave_address;
        logic        new_entry;
        logic [8:0]  entries_in_use;
        logic [31:0] entry_count;
        logic [31:0] total_count;
        logic [7:0]  data_byte;
        logic [8:0]  data_length;
        logic [31:0] data_time;
    } t_out_item;

endpackage

`default_nettype wire

>>> hw/rtl/bsmht_rank_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module bsmht_rank_mem #(
    parameter int TABLE_ENTRIES = 256
) (
    input  wire                              i_clk,
    input  wire [$clog2(TABLE_ENTRIES)-1:0]  i_raddr,
    output logic [7:0]                       o_raddr_addr,
    output logic [$clog2(TABLE_ENTRIES)-1:0] o_rdata_slot,
    input  wire                              i_we,
    input  wire [$clog2(TABLE_ENTRIES)-1:0]  i_waddr,
    input  wire [7:0]                        i_wdata_addr,
    input  wire [$clog2(TABLE_ENTRIES)-1:0]  i_wdata_slot
);
    import bsmht_pkg::*;

    localparam int RW = $clog2(TABLE_ENTRIES);

    logic [RW+7:0] r_mem [TABLE_ENTRIES];
    logic [RW+7:0] r_rdata;
    logic          r_rd_zero;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wdata_addr, i_wdata_slot};
        end
        r_rdata   <= r_mem[i_raddr];
        r_rd_zero <= (i_raddr == '0);
    end

    // rank zero is never written: it always holds the broadcast entry in slot zero
    assign o_raddr_addr = r_rd_zero ? BROADCAST_ADDR : r_rdata[RW+7:RW];
    assign o_rdata_slot = r_rd_zero ? '0 : r_rdata[RW-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/bsmht_slot_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module bsmht_slot_mem #(
    parameter int TABLE_ENTRIES = 256,
    parameter int REC_W         = 38
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_clr,
    input  wire [$clog2(TABLE_ENTRIES)-1:0] i_raddr,
    output logic [REC_W-1:0]                o_rdata,
    input  wire                             i_we,
    input  wire [$clog2(TABLE_ENTRIES)-1:0] i_waddr,
    input  wire [REC_W-1:0]                 i_wdata
);
    logic [REC_W-1:0]         r_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_vld;
    logic [REC_W-1:0]         r_rdata;
    logic                     r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[i_raddr];
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
        end
    end

    // a slot not written since reset or clear reads as an empty record
    assign o_rdata = r_rd_vld ? r_rdata : '0;

endmodule

`default_nettype wire

>>> hw/rtl/bsmht_hist_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module bsmht_hist_mem #(
    parameter int ENTRIES = 1024,
    parameter int MESSAGE_BYTES = 256,
    parameter int LW = 9
) (
    input  wire                                      i_clk,
    input  wire                                      i_cap_we,
    input  wire [$clog2(MESSAGE_BYTES)-1:0]          i_cap_waddr,
    input  wire [7:0]                                i_cap_wdata,
    input  wire [$clog2(MESSAGE_BYTES)-1:0]          i_cap_raddr,
    output logic [7:0]                               o_cap_rdata,
    input  wire                                      i_hist_we,
    input  wire [$clog2(ENTRIES)-1:0]                i_hist_waddr,
    input  wire [LW+31:0]                            i_hist_wdata,
    input  wire [$clog2(ENTRIES)-1:0]                i_hist_raddr,
    output logic [LW+31:0]                           o_hist_rdata,
    input  wire                                      i_byte_we,
    input  wire [$clog2(ENTRIES*MESSAGE_BYTES)-1:0]  i_byte_waddr,
    input  wire [7:0]                                i_byte_wdata,
    input  wire [$clog2(ENTRIES*MESSAGE_BYTES)-1:0]  i_byte_raddr,
    output logic [7:0]                               o_byte_rdata
);
    logic [7:0]    r_cap  [MESSAGE_BYTES];
    logic [LW+31:0] r_hist [ENTRIES];
    logic [7:0]    r_byte [ENTRIES*MESSAGE_BYTES];

    always_ff @(posedge i_clk) begin
        if (i_cap_we) begin
            r_cap[i_cap_waddr] <= i_cap_wdata;
        end
        o_cap_rdata <= r_cap[i_cap_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_hist_we) begin
            r_hist[i_hist_waddr] <= i_hist_wdata;
        end
        o_hist_rdata <= r_hist[i_hist_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_byte_we) begin
            r_byte[i_byte_waddr] <= i_byte_wdata;
        end
        o_byte_rdata <= r_byte[i_byte_raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/bus_slave_message_history_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Bus message history table. A message byte without the last flag is only
// captured. A final byte starts the lookup: a linear scan of the sorted rank
// memory (one rank per cycle), then for a new address an insertion that moves
// one rank per cycle from the end down to the insertion point, the slot record
// and history update, and a copy of the captured bytes into history storage at
// one byte per cycle. Scan and shift together visit each rank about once, and
// the result then waits for the result register to be free. A read looks up
// the rank, slot record and history entry in turn. Slot records carry valid
// bits, so reset and clear need no sweep.
module bus_slave_message_history_table #(
    parameter int TABLE_ENTRIES = 256,
    parameter int HISTORY_DEPTH = 4,
    parameter int MESSAGE_BYTES = 256
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  bsmht_pkg::t_in_item   i_in_data,
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output bsmht_pkg::t_out_item  o_out_data
);
    import bsmht_pkg::*;

    localparam int RW    = $clog2(TABLE_ENTRIES);
    localparam int UW    = $clog2(TABLE_ENTRIES + 1);
    localparam int HW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int MW    = $clog2(MESSAGE_BYTES);
    localparam int LW    = $clog2(MESSAGE_BYTES + 1);
    localparam int ENT   = TABLE_ENTRIES * HISTORY_DEPTH;
    localparam int EAW   = $clog2(ENT);
    localparam int BAW   = $clog2(ENT * MESSAGE_BYTES);
    localparam int REC_W = 32 + HW + HISTORY_DEPTH;

    localparam logic [LW-1:0] MSG_MAX  = LW'(MESSAGE_BYTES);
    localparam logic [UW-1:0] TBL_FULL = UW'(TABLE_ENTRIES);
    localparam logic [HW-1:0] HEAD_TOP = HW'(HISTORY_DEPTH - 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SEARCH = 4'd1;
    localparam logic [3:0] S_SHIFT  = 4'd2;
    localparam logic [3:0] S_UPDATE = 4'd3;
    localparam logic [3:0] S_COPY   = 4'd4;
    localparam logic [3:0] S_R_TBL  = 4'd5;
    localparam logic [3:0] S_R_SLOT = 4'd6;
    localparam logic [3:0] S_R_HIST = 4'd7;
    localparam logic [3:0] S_RESULT = 4'd8;

    function automatic logic [EAW-1:0] f_entry(input logic [RW-1:0] s, input logic [HW-1:0] h);
        f_entry = EAW'(s) * EAW'(HISTORY_DEPTH) + EAW'(h);
    endfunction

    function automatic logic [BAW-1:0] f_baddr(input logic [EAW-1:0] e, input logic [MW-1:0] p);
        f_baddr = BAW'(e) * BAW'(MESSAGE_BYTES) + BAW'(p);
    endfunction

    logic [3:0]   r_state, n_state;
    logic [UW-1:0] r_used, n_used;
    logic [31:0]  r_total, n_total;
    logic [7:0]   r_cap_addr, n_cap_addr;
    logic [LW-1:0] r_cap_len, n_cap_len;
    logic         r_cap_ovf, n_cap_ovf;
    logic [7:0]   r_msg_addr, n_msg_addr;
    logic [LW-1:0] r_msg_len, n_msg_len;
    logic         r_trunc, n_trunc;
    logic [31:0]  r_stamp, n_stamp;
    logic [UW-1:0] r_idx, n_idx;
    logic [RW-1:0] r_rank, n_rank;
    logic [RW-1:0] r_slot, n_slot;
    logic         r_new, n_new;
    logic [EAW-1:0] r_entry, n_entry;
    logic [LW-1:0] r_pos, n_pos;
    logic [7:0]   r_rd_rank, n_rd_rank;
    logic [1:0]   r_rd_hslot, n_rd_hslot;
    logic [7:0]   r_rd_pos, n_rd_pos;
    t_out_item    r_res, n_res;
    t_out_item    r_out, n_out;
    logic         r_out_vld, n_out_vld;

    logic [RW-1:0]  t_raddr, t_waddr, t_wslot, t_rslot;
    logic [7:0]     t_raddr_addr, t_waddr_addr;
    logic           t_we;
    logic [RW-1:0]  s_raddr;
    logic [REC_W-1:0] s_rdata, s_wdata;
    logic           s_we, s_clr;
    logic [MW-1:0]  c_waddr, c_raddr;
    logic [7:0]     c_rdata;
    logic           c_we;
    logic           h_we;
    logic [EAW-1:0] h_waddr, h_raddr;
    logic [LW+31:0] h_wdata, h_rdata;
    logic           b_we;
    logic [BAW-1:0] b_waddr, b_raddr;
    logic [7:0]     b_wdata, b_rdata;

    logic [31:0]    rec_count;
    logic [HW-1:0]  rec_head, nh, hs, hsel;
    logic [HISTORY_DEPTH-1:0] rec_mask;
    logic           stop, found;

    assign {rec_count, rec_head, rec_mask} = s_rdata;
    assign nh   = (rec_head == HEAD_TOP) ? '0 : rec_head + 1'b1;
    assign hs   = HW'(r_rd_hslot);
    assign hsel = (hs <= rec_head) ? rec_head - hs : rec_head + HW'(HISTORY_DEPTH) - hs;
    assign stop  = (r_idx == r_used) || (t_raddr_addr >= r_msg_addr);
    assign found = (r_idx != r_used) && (t_raddr_addr == r_msg_addr);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_comb begin
        n_state = r_state;      n_used = r_used;       n_total = r_total;
        n_cap_addr = r_cap_addr; n_cap_len = r_cap_len; n_cap_ovf = r_cap_ovf;
        n_msg_addr = r_msg_addr; n_msg_len = r_msg_len; n_trunc = r_trunc;
        n_stamp = r_stamp;      n_idx = r_idx;         n_rank = r_rank;
        n_slot = r_slot;        n_new = r_new;         n_entry = r_entry;
        n_pos = r_pos;          n_rd_rank = r_rd_rank; n_rd_hslot = r_rd_hslot;
        n_rd_pos = r_rd_pos;    n_res = r_res;         n_out = r_out;
        n_out_vld = r_out_vld && !i_out_ready;

        t_raddr = '0; t_we = 1'b0; t_waddr = '0; t_waddr_addr = '0; t_wslot = '0;
        s_raddr = '0; s_we = 1'b0; s_wdata = '0; s_clr = 1'b0;
        c_we = 1'b0; c_waddr = '0; c_raddr = '0;
        h_we = 1'b0; h_waddr = '0; h_wdata = '0; h_raddr = '0;
        b_we = 1'b0; b_waddr = '0; b_wdata = '0; b_raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_data.action)
                        ACT_MSG: begin
                            if (r_cap_len == '0 && !r_cap_ovf) begin
                                n_cap_addr = i_in_data.msg_byte;
                            end
                            if (r_cap_len < MSG_MAX) begin
                                c_we      = 1'b1;
                                c_waddr   = r_cap_len[MW-1:0];
                                n_cap_len = r_cap_len + 1'b1;
                            end else begin
                                n_cap_ovf = 1'b1;
                            end
                            if (i_in_data.msg_last) begin
                                n_msg_addr = n_cap_addr;
                                n_msg_len  = n_cap_len;
                                n_trunc    = n_cap_ovf;
                                n_stamp    = i_in_data.time_stamp;
                                n_total    = (r_total >= TOTAL_LIMIT) ? '0 : r_total + 1'b1;
                                n_cap_addr = '0;
                                n_cap_len  = '0;
                                n_cap_ovf  = 1'b0;
                                n_idx      = '0;
                                t_raddr    = '0;
                                n_state    = S_SEARCH;
                            end
                        end
                        ACT_READ: begin
                            n_rd_rank  = i_in_data.read_rank;
                            n_rd_hslot = i_in_data.read_slot;
                            n_rd_pos   = i_in_data.read_position;
                            if ({1'b0, i_in_data.read_rank} >= 9'(r_used)) begin
                                n_res = '0;
                                n_res.status         = ST_READ;
                                n_res.entry_rank     = i_in_data.read_rank;
                                n_res.entries_in_use = 9'(r_used);
                                n_res.total_count    = r_total;
                                n_state = S_RESULT;
                            end else begin
                                t_raddr = RW'(i_in_data.read_rank);
                                n_state = S_R_TBL;
                            end
                        end
                        ACT_CLEAR: begin
                            n_used     = UW'(1);
                            s_clr      = 1'b1;
                            n_cap_addr = '0;
                            n_cap_len  = '0;
                            n_cap_ovf  = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (!stop) begin
                    n_idx   = r_idx + 1'b1;
                    t_raddr = RW'(r_idx + 1'b1);
                end else if (found) begin
                    n_rank  = RW'(r_idx);
                    n_slot  = t_rslot;
                    n_new   = 1'b0;
                    s_raddr = t_rslot;
                    n_state = S_UPDATE;
                end else if (r_used == TBL_FULL) begin
                    n_res = '0;
                    n_res.status         = ST_DROPPED;
                    n_res.slave_address  = r_msg_addr;
                    n_res.entries_in_use = 9'(r_used);
                    n_res.total_count    = r_total;
                    n_state = S_RESULT;
                end else begin
                    // insert: move ranks up from the end, new slot is the next free one
                    n_rank  = RW'(r_idx);
                    n_slot  = RW'(r_used);
                    n_new   = 1'b1;
                    n_idx   = r_used;
                    t_raddr = RW'(r_used - 1'b1);
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                t_we = 1'b1;
                t_waddr = RW'(r_idx);
                if (r_idx != UW'(r_rank)) begin
                    t_waddr_addr = t_raddr_addr;
                    t_wslot      = t_rslot;
                    t_raddr      = RW'(r_idx - 2'd2);
                    n_idx        = r_idx - 1'b1;
                end else begin
                    t_waddr_addr = r_msg_addr;
                    t_wslot      = r_slot;
                    n_used       = r_used + 1'b1;
                    s_raddr      = r_slot;
                    n_state      = S_UPDATE;
                end
            end
            S_UPDATE: begin
                s_we    = 1'b1;
                s_wdata = {rec_count + 1'b1, nh, rec_mask | (HISTORY_DEPTH'(1) << nh)};
                h_we    = 1'b1;
                h_waddr = f_entry(r_slot, nh);
                h_wdata = {r_msg_len, r_stamp};
                n_entry = f_entry(r_slot, nh);
                n_pos   = '0;
                c_raddr = '0;
                n_res = '0;
                n_res.status         = r_trunc ? ST_TRUNC : ST_RECORDED;
                n_res.entry_rank     = 8'(r_rank);
                n_res.slave_address  = r_msg_addr;
                n_res.new_entry      = r_new;
                n_res.entries_in_use = 9'(r_used);
                n_res.entry_count    = rec_count + 1'b1;
                n_res.total_count    = r_total;
                n_state = S_COPY;
            end
            S_COPY: begin
                if (r_pos < r_msg_len) begin
                    b_we    = 1'b1;
                    b_waddr = f_baddr(r_entry, r_pos[MW-1:0]);
                    b_wdata = c_rdata;
                    n_pos   = r_pos + 1'b1;
                    c_raddr = MW'(r_pos + 1'b1);
                end else begin
                    n_state = S_RESULT;
                end
            end
            S_R_TBL: begin
                n_res = '0;
                n_res.status         = ST_READ;
                n_res.entry_rank     = r_rd_rank;
                n_res.slave_address  = t_raddr_addr;
                n_res.entries_in_use = 9'(r_used);
                n_res.total_count    = r_total;
                s_raddr = t_rslot;
                n_slot  = t_rslot;
                n_state = S_R_SLOT;
            end
            S_R_SLOT: begin
                n_res.entry_count = rec_count;
                if (32'(r_rd_hslot) >= 32'(HISTORY_DEPTH) || !rec_mask[hsel]) begin
                    n_state = S_RESULT;
                end else begin
                    h_raddr = f_entry(r_slot, hsel);
                    b_raddr = f_baddr(f_entry(r_slot, hsel), r_rd_pos[MW-1:0]);
                    n_state = S_R_HIST;
                end
            end
            S_R_HIST: begin
                n_res.data_length = 9'(h_rdata[LW+31:32]);
                n_res.data_time   = h_rdata[31:0];
                n_res.data_byte   = ({1'b0, r_rd_pos} < 9'(h_rdata[LW+31:32])) ? b_rdata : '0;
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_vld || i_out_ready) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= UW'(1);
            r_total   <= '0;
            r_cap_addr <= '0;
            r_cap_len <= '0;
            r_cap_ovf <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_total   <= n_total;
            r_cap_addr <= n_cap_addr;
            r_cap_len <= n_cap_len;
            r_cap_ovf <= n_cap_ovf;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_msg_addr <= n_msg_addr;
        r_msg_len  <= n_msg_len;
        r_trunc    <= n_trunc;
        r_stamp    <= n_stamp;
        r_idx      <= n_idx;
        r_rank     <= n_rank;
        r_slot     <= n_slot;
        r_new      <= n_new;
        r_entry    <= n_entry;
        r_pos      <= n_pos;
        r_rd_rank  <= n_rd_rank;
        r_rd_hslot <= n_rd_hslot;
        r_rd_pos   <= n_rd_pos;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    bsmht_rank_mem #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_rank (
        .i_clk        (i_clk),
        .i_raddr      (t_raddr),
        .o_raddr_addr (t_raddr_addr),
        .o_rdata_slot (t_rslot),
        .i_we         (t_we),
        .i_waddr      (t_waddr),
        .i_wdata_addr (t_waddr_addr),
        .i_wdata_slot (t_wslot)
    );

    bsmht_slot_mem #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .REC_W        (REC_W)
    ) u_slot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (s_clr),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata),
        .i_we    (s_we),
        .i_waddr (r_slot),
        .i_wdata (s_wdata)
    );

    bsmht_hist_mem #(
        .ENTRIES      (ENT),
        .MESSAGE_BYTES(MESSAGE_BYTES),
        .LW           (LW)
    ) u_hist (
        .i_clk        (i_clk),
        .i_cap_we     (c_we),
        .i_cap_waddr  (c_waddr),
        .i_cap_wdata  (i_in_data.msg_byte),
        .i_cap_raddr  (c_raddr),
        .o_cap_rdata  (c_rdata),
        .i_hist_we    (h_we),
        .i_hist_waddr (h_waddr),
        .i_hist_wdata (h_wdata),
        .i_hist_raddr (h_raddr),
        .o_hist_rdata (h_rdata),
        .i_byte_we    (b_we),
        .i_byte_waddr (b_waddr),
        .i_byte_wdata (b_wdata),
        .i_byte_raddr (b_raddr),
        .o_byte_rdata (b_rdata)
    );

endmodule

`default_nettype wire

>>> verif/bsmht_checker.sv
`timescale 1ns / 1ps

module bsmht_checker (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_in_ready,
    input  bsmht_pkg::t_in_item  i_in_data,
    input  wire                  i_out_valid,
    input  wire                  i_out_ready,
    input  bsmht_pkg::t_out_item i_out_data,
    output int                   o_fail_count,
    output int                   o_pending
);
    import bsmht_pkg::*;

    localparam int ENTRIES = 256;
    localparam int DEPTH   = 4;
    localparam int MSG_MAX = 256;

    logic [7:0]  rank_addr [ENTRIES];
    logic [7:0]  rank_slot [ENTRIES];
    int unsigned used_cnt;
    logic [31:0] slot_msgs [ENTRIES];
    logic [1:0]  slot_head [ENTRIES];
    logic [8:0]  hist_len  [ENTRIES*DEPTH];
    logic [31:0] hist_time [ENTRIES*DEPTH];
    logic [7:0]  hist_data [ENTRIES*DEPTH*MSG_MAX];
    logic [31:0] msg_total;
    logic [7:0]  cap_addr;
    int unsigned cap_len;
    bit          cap_ovf;
    logic [7:0]  cap_buf [MSG_MAX];

    t_out_item expected_results[$];
    int fails = 0;
    int pending_cnt = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending_cnt;

    task automatic wipe_table();
        for (int i = 0; i < ENTRIES; i++) begin
            rank_addr[i] = '0;
            rank_slot[i] = '0;
            slot_msgs[i] = '0;
            slot_head[i] = '0;
        end
        for (int i = 0; i < ENTRIES*DEPTH; i++) begin
            hist_len[i]  = '0;
            hist_time[i] = '0;
        end
        rank_addr[0] = BROADCAST_ADDR;
        used_cnt = 1;
    endtask

    task automatic drop_capture();
        cap_len  = 0;
        cap_ovf  = 0;
        cap_addr = '0;
    endtask

    function automatic t_out_item blank_result(logic [1:0] st, logic [7:0] rk);
        t_out_item r;
        r = '0;
        r.status         = st;
        r.entry_rank     = rk;
        r.entries_in_use = used_cnt[8:0];
        r.total_count    = msg_total;
        return r;
    endfunction

    task automatic record_message(logic [31:0] stamp);
        t_out_item r;
        int unsigned rk;
        int unsigned sl;
        int unsigned ent;
        bit fresh;
        rk = 0;
        fresh = 0;
        msg_total = msg_total + 1;
        if (msg_total > TOTAL_LIMIT) msg_total = '0;
        while (rk < used_cnt && rank_addr[rk] < cap_addr) rk++;
        if (!(rk < used_cnt && rank_addr[rk] == cap_addr)) begin
            if (used_cnt >= ENTRIES) begin
                r = blank_result(ST_DROPPED, '0);
                r.slave_address = cap_addr;
                expected_results.push_back(r);
                drop_capture();
                return;
            end
            for (int k = used_cnt; k > rk; k--) begin
                rank_addr[k] = rank_addr[k-1];
                rank_slot[k] = rank_slot[k-1];
            end
            rank_addr[rk] = cap_addr;
            rank_slot[rk] = used_cnt[7:0];
            used_cnt++;
            fresh = 1;
        end
        sl = rank_slot[rk];
        slot_head[sl] = slot_head[sl] + 2'd1;
        ent = sl * DEPTH + slot_head[sl];
        hist_len[ent]  = cap_len[8:0];
        hist_time[ent] = stamp;
        for (int i = 0; i < cap_len; i++) hist_data[ent*MSG_MAX + i] = cap_buf[i];
        slot_msgs[sl] = slot_msgs[sl] + 1;
        r = blank_result(cap_ovf ? ST_TRUNC : ST_RECORDED, rk[7:0]);
        r.slave_address = cap_addr;
        r.new_entry     = fresh;
        r.entry_count   = slot_msgs[sl];
        expected_results.push_back(r);
        drop_capture();
    endtask

    task automatic read_entry(t_in_item it);
        t_out_item r;
        int unsigned sl;
        int unsigned ent;
        r = blank_result(ST_READ, it.read_rank);
        if (it.read_rank < used_cnt) begin
            sl  = rank_slot[it.read_rank];
            ent = sl * DEPTH + 2'(slot_head[sl] - it.read_slot);
            r.slave_address = rank_addr[it.read_rank];
            r.entry_count   = slot_msgs[sl];
            r.data_length   = hist_len[ent];
            r.data_time     = hist_time[ent];
            if (it.read_position < hist_len[ent])
                r.data_byte = hist_data[ent*MSG_MAX + it.read_position];
        end
        expected_results.push_back(r);
    endtask

    task automatic apply_item(t_in_item it);
        case (it.action)
            ACT_MSG: begin
                if (cap_len == 0 && !cap_ovf) cap_addr = it.msg_byte;
                if (cap_len < MSG_MAX) begin
                    cap_buf[cap_len] = it.msg_byte;
                    cap_len++;
                end else begin
                    cap_ovf = 1;
                end
                if (it.msg_last) record_message(it.time_stamp);
            end
            ACT_READ:  read_entry(it);
            ACT_CLEAR: begin
                wipe_table();
                drop_capture();
            end
            default: ;
        endcase
    endtask

    task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act) begin
            $error("%s: expected %0h, got %0h", name, exp, act);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            wipe_table();
            drop_capture();
            msg_total = '0;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transfer %0h", i_out_data);
                    fails++;
                end else begin
                    e = expected_results.pop_front();
                    check_field("status", 32'(e.status), 32'(i_out_data.status));
                    check_field("entry_rank", 32'(e.entry_rank),
                                32'(i_out_data.entry_rank));
                    check_field("slave_address", 32'(e.slave_address),
                                32'(i_out_data.slave_address));
                    check_field("new_entry", 32'(e.new_entry),
                                32'(i_out_data.new_entry));
                    check_field("entries_in_use", 32'(e.entries_in_use),
                                32'(i_out_data.entries_in_use));
                    check_field("entry_count", e.entry_count, i_out_data.entry_count);
                    check_field("total_count", e.total_count, i_out_data.total_count);
                    check_field("data_byte", 32'(e.data_byte),
                                32'(i_out_data.data_byte));
                    check_field("data_length", 32'(e.data_length),
                                32'(i_out_data.data_length));
                    check_field("data_time", e.data_time, i_out_data.data_time);
                end
            end
            if (i_in_valid && i_in_ready) apply_item(i_in_data);
        end
        pending_cnt = expected_results.size();
    end

endmodule

>>> verif/bus_slave_message_history_table_tb.sv
`timescale 1ns / 1ps

module bus_slave_message_history_table_tb;
    import bsmht_pkg::*;

    localparam int CYCLE_LIMIT = 4_000_000;

    logic      clk = 0;
    logic      rst_n = 0;
    logic      in_valid = 0;
    logic      in_ready;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_ready = 0;
    t_out_item out_data;
    int        fail_count;
    int        pending;
    bit        calm = 0;
    int        cycles = 0;

    logic [7:0] addr_pool [12] = '{8'h00, 8'h01, 8'h02, 8'h10, 8'h3C, 8'h55,
                                   8'h7F, 8'h80, 8'hAA, 8'hC3, 8'hFE, 8'hFF};

    bus_slave_message_history_table dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data)
    );

    bsmht_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("bus_slave_message_history_table_tb failed");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off early to back up the block
    initial begin
        int burst;
        int hold;
        int tick;
        burst = 0;
        hold = 0;
        tick = 0;
        forever begin
            @(negedge clk);
            tick++;
            if (tick == 3000) hold = 600;
            if (hold > 0) begin
                hold--;
                out_ready <= 1'b0;
            end else if (calm) begin
                out_ready <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                out_ready <= 1'b0;
            end else if ($urandom_range(7) == 0) begin
                burst = $urandom_range(2);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send_item(t_in_item it);
        int gap;
        gap = (!calm && $urandom_range(5) == 0) ? $urandom_range(3, 1) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    function automatic t_in_item noise_fields();
        t_in_item it;
        it = '0;
        it.msg_byte      = 8'($urandom);
        it.time_stamp    = $urandom;
        it.read_rank     = 8'($urandom);
        it.read_slot     = 2'($urandom);
        it.read_position = 8'($urandom);
        return it;
    endfunction

    task automatic send_message(logic [7:0] addr, int len, logic [31:0] stamp);
        t_in_item it;
        for (int i = 0; i < len; i++) begin
            it = noise_fields();
            it.action   = ACT_MSG;
            it.msg_byte = (i == 0) ? addr : 8'($urandom);
            it.msg_last = (i == len - 1);
            it.time_stamp = stamp;
            send_item(it);
        end
    endtask

    task automatic send_read(logic [7:0] rk, logic [1:0] sl, logic [7:0] pos);
        t_in_item it;
        it = noise_fields();
        it.action        = ACT_READ;
        it.read_rank     = rk;
        it.read_slot     = sl;
        it.read_position = pos;
        send_item(it);
    endtask

    task automatic send_code(logic [1:0] act);
        t_in_item it;
        it = noise_fields();
        it.action = act;
        send_item(it);
    endtask

    task automatic random_burst(int n);
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 55)
                send_message(($urandom_range(4) == 0) ? 8'($urandom)
                             : addr_pool[$urandom_range(11)],
                             $urandom_range(6, 1), $urandom);
            else if (pick < 85)
                send_read(($urandom_range(5) == 0) ? 8'($urandom) : 8'($urandom_range(15)),
                          2'($urandom),
                          ($urandom_range(5) == 0) ? 8'($urandom) : 8'($urandom_range(7)));
            else if (pick < 88)
                send_code(ACT_CLEAR);
            else if (pick < 90)
                send_code(ACT_NONE);
            else if (pick < 91)
                send_message(addr_pool[$urandom_range(11)], $urandom_range(40, 20), $urandom);
            else begin
                // message cut short by a clear
                send_message(addr_pool[$urandom_range(11)], 0, 0);
                send_item('{action: ACT_MSG, msg_byte: 8'($urandom), msg_last: 1'b0,
                            time_stamp: 32'($urandom), read_rank: 8'd0,
                            read_slot: 2'd0, read_position: 8'd0});
                send_code(ACT_CLEAR);
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: broadcast, extreme addresses, truncation, empty slots, bad ranks
        send_read(8'd0, 2'd0, 8'd0);
        send_read(8'd255, 2'd3, 8'd255);
        send_message(8'h00, 1, 32'h0000_0000);
        send_message(8'hFF, 3, 32'hFFFF_FFFF);
        send_message(8'h01, 256, 32'h1234_5678);
        send_message(8'h80, 258, 32'hA5A5_5A5A);
        send_message(8'hFF, 2, 32'h5A5A_A5A5);
        send_read(8'd3, 2'd0, 8'd255);
        send_read(8'd3, 2'd1, 8'd1);
        send_read(8'd2, 2'd0, 8'd255);
        send_read(8'd1, 2'd0, 8'd0);
        send_read(8'd1, 2'd3, 8'd0);
        send_read(8'd4, 2'd0, 8'd0);
        send_code(ACT_NONE);
        send_code(ACT_CLEAR);
        send_read(8'd1, 2'd0, 8'd0);
        send_message(8'h7F, 1, 32'h0000_0001);

        random_burst(45);

        // fill the table with every address
        for (int a = 0; a < 256; a++) send_message(8'(a), 1, $urandom);
        send_read(8'd255, 2'd0, 8'd0);
        send_read(8'd255, 2'd2, 8'd0);
        send_message(8'hFF, 2, $urandom);

        calm = 1;
        random_burst(15);

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (1000) @(posedge clk);
        if (fail_count == 0)
            $display("bus_slave_message_history_table_tb passed");
        else
            $display("bus_slave_message_history_table_tb failed");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/bsmht_pkg.sv
hw/rtl/bsmht_rank_mem.sv
hw/rtl/bsmht_slot_mem.sv
hw/rtl/bsmht_hist_mem.sv
hw/rtl/bus_slave_message_history_table.sv
verif/bsmht_checker.sv
verif/bus_slave_message_history_table_tb.sv
